/* src/rq_pkg.sv */
// Package for the randomized queue: operation and status codes, FSM state type.
`default_nettype none
package rq_pkg;

    // Operation codes carried by the kind field of a request word.
    typedef enum logic [1:0] {
        KIND_ENQUEUE = 2'd0,
        KIND_DEQUEUE = 2'd1,
        KIND_SAMPLE  = 2'd2
    } kind_t;

    // Status codes returned with every response word.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Control sequencer states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Fixed field widths of the request and response words.
    localparam int KIND_W   = 2;
    localparam int ITEM_W   = 32;
    localparam int RANDOM_W = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_OUT_W = 9;

endpackage
`default_nettype wire

/* src/rq_if.sv */
// Valid/ready channel interfaces for request and response words.
`default_nettype none
interface rq_req_if;
    logic                                valid;
    logic                                ready;
    logic        [rq_pkg::KIND_W-1:0]    kind;
    logic signed [rq_pkg::ITEM_W-1:0]    item_in;
    logic        [rq_pkg::RANDOM_W-1:0]  random_word;

    modport source (output valid, output kind, output item_in, output random_word,
                    input ready);
    modport sink   (input valid, input kind, input item_in, input random_word,
                    output ready);
endinterface

interface rq_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [rq_pkg::ITEM_W-1:0]      item_out;
    logic        [rq_pkg::STATUS_W-1:0]    status;
    logic        [rq_pkg::COUNT_OUT_W-1:0] count_out;

    modport source (output valid, output item_out, output status, output count_out,
                    input ready);
    modport sink   (input valid, input item_out, input status, input count_out,
                    output ready);
endinterface
`default_nettype wire

/* src/rq_store.sv */
// Entry store: one write port and two registered read ports.
`default_nettype none
module rq_store #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  wire logic                      clk,
    input  wire logic                      rd_en,
    input  wire logic [ADDR_W-1:0]         rd_a_addr,
    input  wire logic [ADDR_W-1:0]         rd_b_addr,
    output logic      [rq_pkg::ITEM_W-1:0] rd_a_data,
    output logic      [rq_pkg::ITEM_W-1:0] rd_b_data,
    input  wire logic                      wr_en,
    input  wire logic [ADDR_W-1:0]         wr_addr,
    input  wire logic [rq_pkg::ITEM_W-1:0] wr_data
);
    import rq_pkg::*;

    logic [ITEM_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read ports; data holds until the next enabled read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_data <= mem[rd_a_addr];
            rd_b_data <= mem[rd_b_addr];
        end
    end

endmodule
`default_nettype wire

/* src/randomized_queue.sv */
// Top level of the randomized queue: sequencer, count register and response register.
//
//   channel | dir | word fields
//   --------+-----+------------------------------------
//   req     | in  | kind, item_in, random_word
//   rsp     | out | item_out, status, count_out
//
// For each word, the accept cycle issues reads of the random slot
// and the last slot, and the execute cycle takes the read data, writes the
// store at most once (append or move of the last entry) and loads the response register.
// req.ready is high only in the idle state, so one word is in work at a time.
// The execute cycle holds while the response register is full and not taken.
// Reset clears state, count and response valid; the store needs no clearing pass.
`default_nettype none
module randomized_queue #(
    parameter int CAPACITY = 256
) (
    input wire logic  clk,
    input wire logic  rst_n,
    rq_req_if.sink    req,
    rq_rsp_if.source  rsp
);
    import rq_pkg::*;

    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int PROD_W  = RANDOM_W + COUNT_W;
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(CAPACITY);

    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [KIND_W-1:0]    kind_reg;
    logic [ITEM_W-1:0]    item_reg;
    logic [IDX_W-1:0]     slot_reg;

    logic                 out_valid_reg;
    logic [ITEM_W-1:0]    out_item_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;

    logic                 req_fire;
    logic                 exec_done;
    logic [PROD_W-1:0]    product;
    logic [IDX_W-1:0]     slot_idx;
    logic [IDX_W-1:0]     last_idx;
    logic [ITEM_W-1:0]    rd_a_data, rd_b_data;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [ITEM_W-1:0]    wr_data;
    logic [ITEM_W-1:0]    value;
    status_t              status;
    logic [COUNT_W+COUNT_OUT_W-1:0] count_ext;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;

    // Random slot is (random_word * count) >> 16, always below a nonzero count.
    assign product  = PROD_W'(req.random_word) * PROD_W'(count_reg);
    assign slot_idx = product[RANDOM_W+IDX_W-1:RANDOM_W];
    assign last_idx = IDX_W'(count_reg - 1'b1);

    // Execute completes once the response register can take a new word.
    assign exec_done = (state_reg == ST_EXEC) && (!out_valid_reg || rsp.ready);

    rq_store #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W)
    ) u_store (
        .clk       (clk),
        .rd_en     (req_fire),
        .rd_a_addr (slot_idx),
        .rd_b_addr (last_idx),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // Capture the request word while its reads are in flight.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            kind_reg <= req.kind;
            item_reg <= req.item_in;
            slot_reg <= slot_idx;
        end
    end

    // Operation decode in the execute cycle.
    always_comb
    begin
        wr_en      = 1'b0;
        wr_addr    = slot_reg;
        wr_data    = rd_b_data;
        value      = '0;
        status     = STATUS_OK;
        count_next = count_reg;
        unique case (kind_reg)
            KIND_ENQUEUE:
            begin
                if (count_reg == FULL_COUNT)
                begin
                    status = STATUS_FULL;
                end
                else
                begin
                    wr_en      = exec_done;
                    wr_addr    = count_reg[IDX_W-1:0];
                    wr_data    = item_reg;
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_DEQUEUE:
            begin
                if (count_reg == '0)
                begin
                    status = STATUS_EMPTY;
                end
                else
                begin
                    value      = rd_a_data;
                    wr_en      = exec_done;
                    count_next = count_reg - 1'b1;
                end
            end
            KIND_SAMPLE:
            begin
                if (count_reg == '0)
                begin
                    status = STATUS_EMPTY;
                end
                else
                begin
                    value = rd_a_data;
                end
            end
            default:
            begin
                value = '0;
            end
        endcase
    end

    assign count_ext = (COUNT_W + COUNT_OUT_W)'(count_next);

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, count and response valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_done)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload.
    always_ff @(posedge clk)
    begin
        if (exec_done)
        begin
            out_item_reg   <= value;
            out_status_reg <= status;
            out_count_reg  <= count_ext[COUNT_OUT_W-1:0];
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.item_out  = out_item_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.count_out = out_count_reg;

endmodule
`default_nettype wire

/* src/rq_checker.sv */
// Port-level assertions for the randomized queue and their bind.
`default_nettype none
module rq_checker #(
    parameter int CAPACITY = 256
) (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            req_valid,
    input wire logic                            req_ready,
    input wire logic                            rsp_valid,
    input wire logic                            rsp_ready,
    input wire logic [rq_pkg::ITEM_W-1:0]       rsp_item_out,
    input wire logic [rq_pkg::STATUS_W-1:0]     rsp_status,
    input wire logic [rq_pkg::COUNT_OUT_W-1:0]  rsp_count_out
);
    import rq_pkg::*;

    localparam logic [COUNT_OUT_W-1:0] FULL_CNT = COUNT_OUT_W'(CAPACITY);

    // A waiting response word holds still until taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item_out)
            && $stable(rsp_status) && $stable(rsp_count_out))
        else $error("response word changed while stalled");

    // The block is busy in the cycle after it accepts a request word.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted back to back");

    // An empty error leaves the queue empty and returns zero.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_item_out == '0
            && rsp_count_out == '0)
        else $error("empty status with data or nonzero count");

    // A full error reports a full queue and returns zero.
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == STATUS_FULL |-> rsp_item_out == '0
            && rsp_count_out == FULL_CNT)
        else $error("full status with data or wrong count");

endmodule

bind randomized_queue rq_checker #(.CAPACITY(CAPACITY)) u_rq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_item_out  (rsp.item_out),
    .rsp_status    (rsp.status),
    .rsp_count_out (rsp.count_out)
);
`default_nettype wire
